// ----- rtl/rhht_pkg.sv -----
// ----------------------------------------------------------------------------
// rhht_pkg
// Shared types and constants for the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhht_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_FRD,
    S_FCHK,
    S_IRD,
    S_ICHK,
    S_SRD,
    S_SCHK
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [31:0] hash_value;
    logic [63:0] value_in;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value_out;
    logic [10:0] entry_total;
  } out_t;

endpackage

// ----- rtl/robin_hood_hash_table.sv -----
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Open-addressed Robin Hood hash table with backward-shift deletion.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory once, clearing one slot per
// cycle, so it accepts no transaction until the sweep is done. Each request
// then runs one at a time under a small sequencer that reads one slot per
// probe from a slot memory with one read and one write port: every probe is
// a registered read, then a compare and at most one write. Insertion of a
// new key adds a second probe run from the home slot until an empty slot is
// found, and delete adds a read and a write-back for every entry that shifts
// back, plus one more probe to find the end of the run. When CAPACITY is not
// a power of two, the home slot is found by a remainder unit that multiplies
// by the reciprocal of the capacity; for a power-of-two capacity the home
// slot is taken directly from the hash bits. One result transaction is
// returned for each request, carrying the status, the value found by a
// lookup (zero otherwise) and the occupied count after the request. A new
// request is taken once the previous result has been handed off.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
  parameter int CAPACITY = rhht_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rhht_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rhht_pkg::out_t out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IW-1:0] LAST  = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  rhht_pkg::state_t state_r, state_nxt;

  logic [1:0]    cmd_r, cmd_nxt;
  logic [63:0]   key_r, key_nxt;     // search key, then the carried key
  logic [63:0]   val_r, val_nxt;     // insert value, then the carried value
  logic [IW-1:0] home_r, home_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] dist_r, dist_nxt;   // probe distance or carried distance
  logic [CW-1:0] n_r, n_nxt;         // slots visited in the current loop
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  rhht_pkg::out_t      out_data_r, out_data_nxt;

  // Memory interface.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic          mem_wvalid;
  logic [IW-1:0] mem_wdist;
  logic [63:0]   mem_wkey;
  logic [63:0]   mem_wval;
  logic          rd_valid;
  logic [IW-1:0] rd_dist;
  logic [63:0]   rd_key;
  logic [63:0]   rd_val;

  logic          mod_done;
  logic [IW-1:0] mod_rem;

  logic            acc;
  logic            fin;
  rhht_pkg::status_t fin_status;
  logic [63:0]     fin_value;
  logic [IW-1:0]   idx_inc, idx_dec;
  logic [CW-1:0]   rd_dist_ext;
  logic            key_hit;
  logic            nf_to_insert;

  assign acc         = in_valid && !in_stall;
  assign in_stall    = !(state_r == rhht_pkg::S_IDLE && !out_valid_r);
  assign idx_inc     = (idx_r == LAST) ? '0 : idx_r + 1'b1;
  assign idx_dec     = (idx_r == '0) ? LAST : idx_r - 1'b1;
  assign rd_dist_ext = CW'(rd_dist);
  assign key_hit     = rd_key == key_r;
  // A miss turns into a Robin Hood insert only for an insert with room left.
  assign nf_to_insert = (cmd_r == rhht_pkg::CMD_INSERT) && (cnt_r < CAP_C);

  rhht_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_valid (mem_wvalid),
    .wr_dist  (mem_wdist),
    .wr_key   (mem_wkey),
    .wr_val   (mem_wval),
    .rd_addr  (idx_r),
    .rd_valid (rd_valid),
    .rd_dist  (rd_dist),
    .rd_key   (rd_key),
    .rd_val   (rd_val)
  );

  rhht_mod #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc && !POW2),
    .hash  (in_data.hash_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rhht_pkg::S_CLEAR: begin
        if (idx_r == LAST) state_nxt = rhht_pkg::S_IDLE;
      end
      rhht_pkg::S_IDLE: begin
        if (acc) begin
          if (in_data.cmd != rhht_pkg::CMD_INSERT && in_data.cmd != rhht_pkg::CMD_LOOKUP &&
              in_data.cmd != rhht_pkg::CMD_DELETE) begin
            state_nxt = rhht_pkg::S_IDLE;
          end else if (POW2) begin
            state_nxt = rhht_pkg::S_FRD;
          end else begin
            state_nxt = rhht_pkg::S_HOME;
          end
        end
      end
      rhht_pkg::S_HOME: begin
        if (mod_done) state_nxt = rhht_pkg::S_FRD;
      end
      rhht_pkg::S_FRD: begin
        if (dist_r == CAP_C) begin
          state_nxt = nf_to_insert ? rhht_pkg::S_IRD : rhht_pkg::S_IDLE;
        end else begin
          state_nxt = rhht_pkg::S_FCHK;
        end
      end
      rhht_pkg::S_FCHK: begin
        if (!rd_valid || (!key_hit && rd_dist_ext < dist_r)) begin
          state_nxt = nf_to_insert ? rhht_pkg::S_IRD : rhht_pkg::S_IDLE;
        end else if (key_hit) begin
          state_nxt = (cmd_r == rhht_pkg::CMD_DELETE) ? rhht_pkg::S_SRD : rhht_pkg::S_IDLE;
        end else begin
          state_nxt = rhht_pkg::S_FRD;
        end
      end
      rhht_pkg::S_IRD: begin
        state_nxt = (n_r == CAP_C) ? rhht_pkg::S_IDLE : rhht_pkg::S_ICHK;
      end
      rhht_pkg::S_ICHK: begin
        state_nxt = !rd_valid ? rhht_pkg::S_IDLE : rhht_pkg::S_IRD;
      end
      rhht_pkg::S_SRD: begin
        state_nxt = (n_r == CAP_C) ? rhht_pkg::S_IDLE : rhht_pkg::S_SCHK;
      end
      rhht_pkg::S_SCHK: begin
        state_nxt = (!rd_valid || rd_dist == '0) ? rhht_pkg::S_IDLE : rhht_pkg::S_SRD;
      end
      default: state_nxt = rhht_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory writes and result.
  always_comb begin
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    home_nxt   = home_r;
    idx_nxt    = idx_r;
    dist_nxt   = dist_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wvalid = 1'b0;
    mem_wdist  = '0;
    mem_wkey   = key_r;
    mem_wval   = val_r;
    fin        = 1'b0;
    fin_status = rhht_pkg::ST_NOT_FOUND;
    fin_value  = '0;

    case (state_r)
      rhht_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
      end
      rhht_pkg::S_IDLE: begin
        if (acc) begin
          cmd_nxt  = in_data.cmd;
          key_nxt  = in_data.key;
          val_nxt  = in_data.value_in;
          dist_nxt = '0;
          if (POW2) begin
            home_nxt = in_data.hash_value[IW-1:0];
            idx_nxt  = in_data.hash_value[IW-1:0];
          end
          if (in_data.cmd != rhht_pkg::CMD_INSERT && in_data.cmd != rhht_pkg::CMD_LOOKUP &&
              in_data.cmd != rhht_pkg::CMD_DELETE) begin
            fin = 1'b1;
          end
        end
      end
      rhht_pkg::S_HOME: begin
        if (mod_done) begin
          home_nxt = mod_rem;
          idx_nxt  = mod_rem;
        end
      end
      rhht_pkg::S_FRD: begin
        if (dist_r == CAP_C) begin
          if (nf_to_insert) begin
            idx_nxt  = home_r;
            dist_nxt = '0;
            n_nxt    = '0;
          end else begin
            fin        = 1'b1;
            fin_status = (cmd_r == rhht_pkg::CMD_INSERT) ? rhht_pkg::ST_FULL
                                                          : rhht_pkg::ST_NOT_FOUND;
          end
        end
      end
      rhht_pkg::S_FCHK: begin
        if (!rd_valid || (!key_hit && rd_dist_ext < dist_r)) begin
          if (nf_to_insert) begin
            idx_nxt  = home_r;
            dist_nxt = '0;
            n_nxt    = '0;
          end else begin
            fin        = 1'b1;
            fin_status = (cmd_r == rhht_pkg::CMD_INSERT) ? rhht_pkg::ST_FULL
                                                          : rhht_pkg::ST_NOT_FOUND;
          end
        end else if (key_hit) begin
          case (cmd_r)
            rhht_pkg::CMD_INSERT: begin
              mem_we     = 1'b1;
              mem_wvalid = 1'b1;
              mem_wdist  = rd_dist;
              mem_wkey   = rd_key;
              mem_wval   = val_r;
              fin        = 1'b1;
              fin_status = rhht_pkg::ST_UPDATED;
            end
            rhht_pkg::CMD_LOOKUP: begin
              fin        = 1'b1;
              fin_status = rhht_pkg::ST_FOUND;
              fin_value  = rd_val;
            end
            default: begin
              // Delete: the hole sits just behind the shift cursor.
              cnt_nxt = cnt_r - 1'b1;
              idx_nxt = idx_inc;
              n_nxt   = '0;
            end
          endcase
        end else begin
          idx_nxt  = idx_inc;
          dist_nxt = dist_r + 1'b1;
        end
      end
      rhht_pkg::S_IRD: begin
        if (n_r == CAP_C) begin
          fin        = 1'b1;
          fin_status = rhht_pkg::ST_INSERTED;
        end
      end
      rhht_pkg::S_ICHK: begin
        if (!rd_valid) begin
          mem_we     = 1'b1;
          mem_wvalid = 1'b1;
          mem_wdist  = dist_r[IW-1:0];
          cnt_nxt    = cnt_r + 1'b1;
          fin        = 1'b1;
          fin_status = rhht_pkg::ST_INSERTED;
        end else begin
          if (rd_dist_ext < dist_r) begin
            // Take the richer slot and carry its entry onward.
            mem_we     = 1'b1;
            mem_wvalid = 1'b1;
            mem_wdist  = dist_r[IW-1:0];
            key_nxt    = rd_key;
            val_nxt    = rd_val;
            dist_nxt   = rd_dist_ext + 1'b1;
          end else begin
            dist_nxt = dist_r + 1'b1;
          end
          idx_nxt = idx_inc;
          n_nxt   = n_r + 1'b1;
        end
      end
      rhht_pkg::S_SRD: begin
        if (n_r == CAP_C) begin
          mem_we     = 1'b1;
          mem_waddr  = idx_dec;
          fin        = 1'b1;
          fin_status = rhht_pkg::ST_DELETED;
        end
      end
      rhht_pkg::S_SCHK: begin
        mem_we    = 1'b1;
        mem_waddr = idx_dec;
        if (!rd_valid || rd_dist == '0) begin
          fin        = 1'b1;
          fin_status = rhht_pkg::ST_DELETED;
        end else begin
          mem_wvalid = 1'b1;
          mem_wdist  = rd_dist - 1'b1;
          mem_wkey   = rd_key;
          mem_wval   = rd_val;
          idx_nxt    = idx_inc;
          n_nxt      = n_r + 1'b1;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fin) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = fin_status;
      out_data_nxt.value_out   = fin_value;
      out_data_nxt.entry_total = 11'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhht_pkg::S_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      dist_r      <= '0;
      cmd_r       <= rhht_pkg::CMD_LOOKUP;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      dist_r      <= dist_nxt;
      cmd_r       <= cmd_nxt;
    end
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    home_r     <= home_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The occupied count can never pass the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C) else $error("occupied count above capacity");

  // An accepted transaction always leaves the idle state or finishes at once.
  a_acc_leave: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != rhht_pkg::S_IDLE || out_valid_r))
    else $error("accepted transaction produced no work");

  // The slot memory is never written while the sequencer is idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rhht_pkg::S_IDLE) |-> !mem_we) else $error("write while idle");

  // Finishing a request raises the result in the next cycle.
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r) else $error("result lost");

endmodule

// ----- rtl/rhht_mem.sv -----
// ----------------------------------------------------------------------------
// rhht_mem
// Slot store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rhht_mem #(
  parameter int DEPTH = rhht_pkg::CAPACITY_DEF,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_valid,
  input  logic [AW-1:0] wr_dist,
  input  logic [63:0]   wr_key,
  input  logic [63:0]   wr_val,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_valid,
  output logic [AW-1:0] rd_dist,
  output logic [63:0]   rd_key,
  output logic [63:0]   rd_val
);

  localparam int EW = 1 + AW + 128;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_dist, wr_key, wr_val};
    end
    rdata_r <= mem[rd_addr];
  end

  assign {rd_valid, rd_dist, rd_key, rd_val} = rdata_r;

endmodule

// ----- rtl/rhht_mod.sv -----
// ----------------------------------------------------------------------------
// rhht_mod
// Remainder of a 32-bit hash by the table capacity, by reciprocal multiply.
// ----------------------------------------------------------------------------
module rhht_mod #(
  parameter int CAPACITY = rhht_pkg::CAPACITY_DEF,
  parameter int IW       = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   hash,
  output logic          done,
  output logic [IW-1:0] rem
);

  // The reciprocal is scaled by 2^(32+IW) and rounded down, so the estimated
  // quotient is the true one or one less, and one final subtract corrects it.
  localparam int QS = 32 + IW;
  localparam logic [32:0] RECIP = 33'((64'd1 << QS) / CAPACITY);
  localparam logic [31:0] CAP_W = 32'(CAPACITY);

  logic        v1_r, v1_nxt;
  logic        v2_r, v2_nxt;
  logic        v3_r, v3_nxt;
  logic [31:0] h_r, h_nxt;
  logic [64:0] prod_r, prod_nxt;
  logic [31:0] raw_r, raw_nxt;
  logic [31:0] quo;
  logic [31:0] fix;

  // Stage one multiplies by the reciprocal, stage two forms the raw
  // remainder and the output applies the single correction.
  always_comb begin
    v1_nxt   = start;
    v2_nxt   = v1_r;
    v3_nxt   = v2_r;
    h_nxt    = start ? hash : h_r;
    prod_nxt = 65'(h_r) * 65'(RECIP);
    quo      = 32'(prod_r >> QS);
    raw_nxt  = h_r - quo * CAP_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
    h_r    <= h_nxt;
    prod_r <= prod_nxt;
    raw_r  <= raw_nxt;
  end

  assign fix  = (raw_r >= CAP_W) ? raw_r - CAP_W : raw_r;
  assign done = v3_r;
  assign rem  = fix[IW-1:0];

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Robin Hood hash table: a behavioral table model
// predicts status, lookup value and occupied count for every request, and a
// checker compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = rhht_pkg::CAPACITY_DEF;
  localparam int MAX_CYCLES = 20000000;
  // Command code that the block treats as no operation.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rhht_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rhht_pkg::out_t out_data;

  always #5 clk = ~clk;

  robin_hood_hash_table #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the table contents. Keys and values of empty slots are
  // never looked at, mirroring the block.
  bit          tbl_used [CAP];
  logic [63:0] tbl_key  [CAP];
  logic [63:0] tbl_val  [CAP];
  int unsigned tbl_dist [CAP];
  int unsigned tbl_count;

  rhht_pkg::out_t expected_results[$];
  int          mismatches;
  int          results_seen;
  int          requests_sent;
  int unsigned cycle_count;
  bit          sender_gaps;   // enables random gaps between bursts
  bit          stall_enable;  // enables the receiver's stall pattern

  // Linear probe with the Robin Hood early stop. Returns the slot or -1.
  function automatic int locate_key(logic [63:0] k, int unsigned home);
    int unsigned idx;
    idx = home;
    for (int unsigned d = 0; d < CAP; d++) begin
      if (!tbl_used[idx]) return -1;
      if (tbl_key[idx] == k) return idx;
      if (tbl_dist[idx] < d) return -1;
      idx = (idx + 1) % CAP;
    end
    return -1;
  endfunction

  function automatic void place_key(logic [63:0] k, logic [63:0] v, int unsigned home);
    int unsigned idx, pdist, td;
    logic [63:0] tk, tv;
    idx = home;
    pdist = 0;
    for (int n = 0; n < CAP; n++) begin
      if (!tbl_used[idx]) begin
        tbl_used[idx] = 1'b1;
        tbl_key[idx] = k;
        tbl_val[idx] = v;
        tbl_dist[idx] = pdist;
        tbl_count++;
        return;
      end
      // A richer resident gives up its slot and the probe carries it on.
      if (tbl_dist[idx] < pdist) begin
        tk = tbl_key[idx]; tv = tbl_val[idx]; td = tbl_dist[idx];
        tbl_key[idx] = k; tbl_val[idx] = v; tbl_dist[idx] = pdist;
        k = tk; v = tv; pdist = td;
      end
      pdist++;
      idx = (idx + 1) % CAP;
    end
  endfunction

  function automatic void remove_and_shift(int unsigned idx);
    int unsigned cur, dst;
    cur = (idx + 1) % CAP;
    tbl_used[idx] = 1'b0;
    tbl_dist[idx] = 0;
    tbl_count--;
    for (int n = 0; n < CAP; n++) begin
      if (!tbl_used[cur] || tbl_dist[cur] == 0) break;
      dst = (cur == 0) ? CAP - 1 : cur - 1;
      tbl_used[dst] = 1'b1;
      tbl_key[dst] = tbl_key[cur];
      tbl_val[dst] = tbl_val[cur];
      tbl_dist[dst] = tbl_dist[cur] - 1;
      tbl_used[cur] = 1'b0;
      tbl_dist[cur] = 0;
      cur = (cur + 1) % CAP;
    end
  endfunction

  function automatic rhht_pkg::out_t apply_request(rhht_pkg::in_t req);
    rhht_pkg::out_t r;
    int where;
    int unsigned home;
    home = req.hash_value % CAP;
    r.status = rhht_pkg::ST_NOT_FOUND;
    r.value_out = '0;
    where = locate_key(req.key, home);
    case (req.cmd)
      rhht_pkg::CMD_INSERT: begin
        if (where >= 0) begin
          tbl_val[where] = req.value_in;
          r.status = rhht_pkg::ST_UPDATED;
        end else if (tbl_count >= CAP) begin
          r.status = rhht_pkg::ST_FULL;
        end else begin
          place_key(req.key, req.value_in, home);
          r.status = rhht_pkg::ST_INSERTED;
        end
      end
      rhht_pkg::CMD_LOOKUP: begin
        if (where >= 0) begin
          r.value_out = tbl_val[where];
          r.status = rhht_pkg::ST_FOUND;
        end
      end
      rhht_pkg::CMD_DELETE: begin
        if (where >= 0) begin
          remove_and_shift(where);
          r.status = rhht_pkg::ST_DELETED;
        end
      end
      default: ;
    endcase
    r.entry_total = tbl_count[10:0];
    return r;
  endfunction

  // Sends one request; the prediction is queued when the transaction is taken.
  // Valid stays high into the next request unless a gap is inserted first.
  task automatic send_request(logic [1:0] c, logic [63:0] k, logic [31:0] h,
                              logic [63:0] v);
    rhht_pkg::in_t req;
    req.cmd = c; req.key = k; req.hash_value = h; req.value_in = v;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_request(req));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Receiver stall pattern: each cycle stalls with a fixed chance.
  always @(negedge clk) begin
    if (stall_enable && ($urandom_range(0, 99) < 30)) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  // Result checker, sampling at the rising edge.
  always @(posedge clk) begin
    rhht_pkg::out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: %p", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status || out_data.value_out !== exp_r.value_out ||
            out_data.entry_total !== exp_r.entry_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d value %h total %0d, got %0d %h %0d",
                     exp_r.status, exp_r.value_out, exp_r.entry_total,
                     out_data.status, out_data.value_out, out_data.entry_total);
        end
      end
    end
  end

  // Watchdog: the clearing sweep plus long probe runs stay far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Directed corners: field extremes, every command, the unused command,
  // updates of an existing key, wrap at the last slot and a shift chain.
  task automatic test_directed();
    send_request(rhht_pkg::CMD_LOOKUP, 64'h0, 32'h0, 64'h0);
    send_request(rhht_pkg::CMD_DELETE, 64'h0, 32'h0, 64'h0);
    send_request(rhht_pkg::CMD_INSERT, 64'h0, 32'h0, 64'h0);
    send_request(rhht_pkg::CMD_INSERT, '1, 32'hFFFF_FFFF, '1);
    send_request(rhht_pkg::CMD_INSERT, 64'h5, 32'hFFFF_FFFF, 64'hAAAA);  // wraps from the last slot to slot 0
    send_request(rhht_pkg::CMD_INSERT, 64'h6, CAP - 1, 64'h5555);
    send_request(rhht_pkg::CMD_LOOKUP, 64'h6, CAP - 1, '1);
    send_request(rhht_pkg::CMD_INSERT, 64'h5, 32'hFFFF_FFFF, 64'h1234);  // update
    send_request(rhht_pkg::CMD_LOOKUP, 64'h5, 32'hFFFF_FFFF, 64'h0);
    send_request(CMD_UNUSED, 64'h5, 32'hFFFF_FFFF, '1);
    send_request(rhht_pkg::CMD_INSERT, 64'h7, 32'h1, 64'h77);
    send_request(rhht_pkg::CMD_DELETE, '1, 32'hFFFF_FFFF, 64'h0);  // shift back over wrap
    send_request(rhht_pkg::CMD_LOOKUP, 64'h5, 32'hFFFF_FFFF, 64'h0);
    send_request(rhht_pkg::CMD_LOOKUP, 64'h7, 32'h1, 64'h0);
    send_request(rhht_pkg::CMD_DELETE, 64'h5, 32'hFFFF_FFFF, 64'h0);
    send_request(rhht_pkg::CMD_DELETE, 64'h6, CAP - 1, 64'h0);
    send_request(rhht_pkg::CMD_DELETE, 64'h7, 32'h1, 64'h0);
    send_request(rhht_pkg::CMD_DELETE, 64'h0, 32'h0, 64'h0);
    wait_drained();
  endtask

  // Random mix over a small key pool so hits, collisions and shifts are common.
  task automatic test_random(int count);
    logic [63:0] pool_key  [32];
    logic [31:0] pool_hash [32];
    int p;
    logic [1:0] c;
    for (int i = 0; i < 32; i++) begin
      pool_key[i]  = {$urandom, $urandom};
      pool_hash[i] = (i < 16) ? ($urandom & 32'hFFFF_FC07) | ($urandom_range(1020, 1023) << 0)
                              : $urandom;
    end
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 31);
      if ($urandom_range(0, 9) < 5)
        c = rhht_pkg::CMD_INSERT;
      else
        c = $urandom_range(0, 1) ? rhht_pkg::CMD_LOOKUP : rhht_pkg::CMD_DELETE;
      if ($urandom_range(0, 49) == 0) c = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0)
        send_request(c, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
      else
        send_request(c, pool_key[p], pool_hash[p], {$urandom, $urandom});
    end
    wait_drained();
  endtask

  initial begin
    mismatches = 0; results_seen = 0; requests_sent = 0; cycle_count = 0;
    sender_gaps = 1'b0; stall_enable = 1'b0; tbl_count = 0;
    for (int i = 0; i < CAP; i++) begin
      tbl_used[i] = 1'b0;
      tbl_dist[i] = 0;
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    sender_gaps = 1'b1; stall_enable = 1'b1;
    test_random(300);
    sender_gaps = 1'b0; stall_enable = 1'b0;
    test_random(150);
    sender_gaps = 1'b1; stall_enable = 1'b1;
    test_random(150);
    $display("ran %0d requests and checked %0d results over all commands,",
             requests_sent, results_seen);
    $display("index wrap, displacement and shift chains, with and without stalls");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
